// ----- src/cpe_pkg.sv -----
// Shared constants and codes for the complex polynomial evaluation unit.
package cpe_pkg;

  localparam int WORD_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int CFG_INDEX_BITS    = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POINT_REAL,
    REG_POINT_IMAG
  } cfg_reg_e;

endpackage

// ----- src/cpe_queue.sv -----
// Small first-in first-out queue built from a register array.
module cpe_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("queue count did not grow on push");

  a_full_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (wr_ptr_q == rd_ptr_q)) else $error("full queue with split pointers");

endmodule

// ----- src/cpe_front.sv -----
// Front end: evaluation point registers and coefficient request intake.
module cpe_front #(
  parameter int WORD_BITS = cpe_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpe_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]              cfg_wdata_i,
  input  logic                              push_i,
  input  logic signed [WORD_BITS-1:0]       coef_real_i,
  input  logic signed [WORD_BITS-1:0]       coef_imag_i,
  input  logic                              last_coef_i,
  output logic                              full_o,
  output logic                              q_push_o,
  output logic [2*WORD_BITS:0]              q_data_o,
  input  logic                              q_full_i,
  output logic signed [WORD_BITS-1:0]       point_real_o,
  output logic signed [WORD_BITS-1:0]       point_imag_o
);
  import cpe_pkg::*;

  logic signed [WORD_BITS-1:0] point_real_q, point_imag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_real_q <= '0;
      point_imag_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POINT_REAL: point_real_q <= cfg_wdata_i;
        REG_POINT_IMAG: point_imag_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign point_real_o = point_real_q;
  assign point_imag_o = point_imag_q;
  assign full_o       = q_full_i;
  assign q_push_o     = push_i && !q_full_i;
  assign q_data_o     = {last_coef_i, coef_imag_i, coef_real_i};

endmodule

// ----- src/cpe_back.sv -----
// Back end: Horner accumulators for value, slope and half curvature.
module cpe_back #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [WORD_BITS-1:0] point_real_i,
  input  logic signed [WORD_BITS-1:0] point_imag_i,
  input  logic                        item_valid_i,
  input  logic [2*WORD_BITS:0]        item_data_i,
  output logic                        item_pop_o,
  input  logic                        res_full_i,
  output logic                        res_push_o,
  output logic [6*WORD_BITS:0]        res_data_o
);
  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W + 1;
  localparam int SW = PW - FRACTION_BITS;
  localparam logic signed [PW-1:0] RND  = PW'(1) <<< (FRACTION_BITS - 1);
  localparam logic [W-1:0]         WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]         WMIN = {1'b1, {(W-1){1'b0}}};

  // Rounded, saturated product; returns {overflow, value}.
  function automatic logic [W:0] fmul(input logic signed [W-1:0] a,
                                      input logic signed [W-1:0] b);
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] shd;
    logic [W:0]           res;
    prod = PW'(a) * PW'(b);
    prod = prod + RND;
    shd  = SW'(prod >>> FRACTION_BITS);
    if ((&shd[SW-1:W-1]) || !(|shd[SW-1:W-1])) begin
      res = {1'b0, shd[W-1:0]};
    end else begin
      res = {1'b1, shd[SW-1] ? WMIN : WMAX};
    end
    return res;
  endfunction

  // Saturating add or subtract; returns {overflow, value}.
  function automatic logic [W:0] sadd(input logic [W-1:0] a, input logic [W-1:0] b,
                                      input logic sub);
    logic signed [W:0] s;
    logic [W:0]        res;
    s = sub ? ($signed({a[W-1], a}) - $signed({b[W-1], b}))
            : ($signed({a[W-1], a}) + $signed({b[W-1], b}));
    if (s[W] == s[W-1]) begin
      res = {1'b0, s[W-1:0]};
    end else begin
      res = {1'b1, s[W] ? WMIN : WMAX};
    end
    return res;
  endfunction

  // (ar + j ai) * point + (cr + j ci); returns {overflow, imag, real}.
  function automatic logic [2*W:0] cmadd(input logic [W-1:0] ar, input logic [W-1:0] ai,
                                         input logic [W-1:0] cr, input logic [W-1:0] ci,
                                         input logic signed [W-1:0] pr,
                                         input logic signed [W-1:0] pi);
    logic [W:0] p_rr, p_ii, p_ri, p_ir, re, im, out_re, out_im;
    p_rr   = fmul($signed(ar), pr);
    p_ii   = fmul($signed(ai), pi);
    p_ri   = fmul($signed(ar), pi);
    p_ir   = fmul($signed(ai), pr);
    re     = sadd(p_rr[W-1:0], p_ii[W-1:0], 1'b1);
    im     = sadd(p_ri[W-1:0], p_ir[W-1:0], 1'b0);
    out_re = sadd(re[W-1:0], cr, 1'b0);
    out_im = sadd(im[W-1:0], ci, 1'b0);
    return {p_rr[W] | p_ii[W] | p_ri[W] | p_ir[W] | re[W] | im[W] | out_re[W] | out_im[W],
            out_im[W-1:0], out_re[W-1:0]};
  endfunction

  logic [W-1:0] val_re_q, val_im_q, slp_re_q, slp_im_q, hcv_re_q, hcv_im_q;
  logic         ovf_q;

  logic [W-1:0] coef_re, coef_im;
  logic         last;
  logic [2*W:0] hcv_n, slp_n, val_n;
  logic [W:0]   dbl_re, dbl_im;
  logic         fire, ovf_n;

  assign coef_re = item_data_i[W-1:0];
  assign coef_im = item_data_i[2*W-1:W];
  assign last    = item_data_i[2*W];

  assign hcv_n  = cmadd(hcv_re_q, hcv_im_q, slp_re_q, slp_im_q, point_real_i, point_imag_i);
  assign slp_n  = cmadd(slp_re_q, slp_im_q, val_re_q, val_im_q, point_real_i, point_imag_i);
  assign val_n  = cmadd(val_re_q, val_im_q, coef_re, coef_im, point_real_i, point_imag_i);
  assign dbl_re = sadd(hcv_n[W-1:0], hcv_n[W-1:0], 1'b0);
  assign dbl_im = sadd(hcv_n[2*W-1:W], hcv_n[2*W-1:W], 1'b0);
  assign ovf_n  = ovf_q | hcv_n[2*W] | slp_n[2*W] | val_n[2*W];

  // One coefficient per cycle unless the result queue is backed up.
  assign fire       = item_valid_i && !res_full_i;
  assign item_pop_o = fire;
  assign res_push_o = fire && last;
  assign res_data_o = {ovf_n | dbl_re[W] | dbl_im[W],
                       dbl_im[W-1:0], dbl_re[W-1:0],
                       slp_n[2*W-1:W], slp_n[W-1:0],
                       val_n[2*W-1:W], val_n[W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_re_q <= '0;
      val_im_q <= '0;
      slp_re_q <= '0;
      slp_im_q <= '0;
      hcv_re_q <= '0;
      hcv_im_q <= '0;
      ovf_q    <= 1'b0;
    end else if (fire) begin
      if (last) begin
        val_re_q <= '0;
        val_im_q <= '0;
        slp_re_q <= '0;
        slp_im_q <= '0;
        hcv_re_q <= '0;
        hcv_im_q <= '0;
        ovf_q    <= 1'b0;
      end else begin
        val_re_q <= val_n[W-1:0];
        val_im_q <= val_n[2*W-1:W];
        slp_re_q <= slp_n[W-1:0];
        slp_im_q <= slp_n[2*W-1:W];
        hcv_re_q <= hcv_n[W-1:0];
        hcv_im_q <= hcv_n[2*W-1:W];
        ovf_q    <= ovf_n;
      end
    end
  end

  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (item_pop_o && !res_full_i)) else $error("result without a consumed item");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last) |=> (val_re_q == '0 && slp_im_q == '0 && hcv_re_q == '0 && !ovf_q))
    else $error("accumulators not cleared after last coefficient");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(val_re_q) && $stable(hcv_im_q) && $stable(ovf_q)))
    else $error("accumulators moved without a coefficient");

endmodule

// ----- src/complex_poly_eval_with_derivatives_unit.sv -----
// Top level: complex polynomial and derivative evaluation by Horner's rule.
// With both queues empty, a result is on the result ports once its last coefficient has passed
//   through the item queue, the back end and the result queue.
// Throughput: one coefficient per cycle; the back end's complex multiply-add recurrence over
//   the three accumulator pairs sets that figure. Requests stall only while the result queue
//   is full and the item queue has filled behind it.
// Reset clears the evaluation point, all accumulators, the overflow flag and both queues.
module complex_poly_eval_with_derivatives_unit #(
  parameter int WORD_BITS     = cpe_pkg::WORD_BITS_DEF,
  parameter int FRACTION_BITS = cpe_pkg::FRACTION_BITS_DEF,
  parameter int QUEUE_DEPTH   = cpe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cpe_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [WORD_BITS-1:0]              cfg_wdata_i,
  // Coefficient requests
  input  logic                              push,
  output logic                              full,
  input  logic signed [WORD_BITS-1:0]       coef_real_i,
  input  logic signed [WORD_BITS-1:0]       coef_imag_i,
  input  logic                              last_coef_i,
  // Results
  output logic                              empty,
  input  logic                              pop,
  output logic signed [WORD_BITS-1:0]       value_real_o,
  output logic signed [WORD_BITS-1:0]       value_imag_o,
  output logic signed [WORD_BITS-1:0]       slope_real_o,
  output logic signed [WORD_BITS-1:0]       slope_imag_o,
  output logic signed [WORD_BITS-1:0]       curvature_real_o,
  output logic signed [WORD_BITS-1:0]       curvature_imag_o,
  output logic                              saturated_o
);
  import cpe_pkg::*;

  localparam int W = WORD_BITS;

  // Front end to item queue
  logic                 iq_push, iq_full, iq_empty, iq_pop;
  logic [2*W:0]         iq_wdata, iq_rdata;
  logic signed [W-1:0]  point_real, point_imag;

  // Back end to result queue
  logic                 rq_push, rq_full;
  logic [6*W:0]         rq_wdata, rq_rdata;

  // Hold the evaluation point and hand coefficient requests to the item queue.
  cpe_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push_i       (push),
    .coef_real_i  (coef_real_i),
    .coef_imag_i  (coef_imag_i),
    .last_coef_i  (last_coef_i),
    .full_o       (full),
    .q_push_o     (iq_push),
    .q_data_o     (iq_wdata),
    .q_full_i     (iq_full),
    .point_real_o (point_real),
    .point_imag_o (point_imag)
  );

  // Decouple intake from the accumulator datapath.
  cpe_queue #(
    .WIDTH(2 * W + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_item_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (iq_push),
    .wdata_i (iq_wdata),
    .full_o  (iq_full),
    .pop_i   (iq_pop),
    .rdata_o (iq_rdata),
    .empty_o (iq_empty)
  );

  // Advance the accumulators one coefficient per cycle while the result queue has room; emit on the last one.
  cpe_back #(
    .WORD_BITS    (WORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .point_real_i (point_real),
    .point_imag_i (point_imag),
    .item_valid_i (!iq_empty),
    .item_data_i  (iq_rdata),
    .item_pop_o   (iq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_data_o   (rq_wdata)
  );

  // Hold finished results until the consumer pops them.
  cpe_queue #(
    .WIDTH(6 * W + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .full_o  (rq_full),
    .pop_i   (pop),
    .rdata_o (rq_rdata),
    .empty_o (empty)
  );

  assign value_real_o     = rq_rdata[W-1:0];
  assign value_imag_o     = rq_rdata[2*W-1:W];
  assign slope_real_o     = rq_rdata[3*W-1:2*W];
  assign slope_imag_o     = rq_rdata[4*W-1:3*W];
  assign curvature_real_o = rq_rdata[5*W-1:4*W];
  assign curvature_imag_o = rq_rdata[6*W-1:5*W];
  assign saturated_o      = rq_rdata[6*W];

endmodule
